### sv/cvkt_pkg.sv
// ============================================================================
// cvkt_pkg - shared types, constants and microprogram of the tracker
// Holds the micro-op format, the scratch memory map, fixed-point helpers and
// the sequencer program that drives the shared multiply-accumulate unit.
// ============================================================================
package cvkt_pkg;

	typedef enum logic [2:0] {
		K_MAC,     // dst = sat(a + b*c)
		K_MACSUB,  // dst = sat(a - b*c)
		K_MACCL,   // dst = clamp48(sat(a + b*c))
		K_DIV,     // dst = round(a * 2^48 / b)
		K_BROBS,   // branch on the observation flag and tracking state
		K_BRDET,   // finish early when the last result was zero
		K_END      // mark update and finish
	} uop_kind_t;

	typedef logic [6:0] src_t;
	typedef logic [5:0] addr_t;

	typedef struct packed {
		uop_kind_t kind;
		addr_t     dst;
		src_t      a;
		src_t      b;
		src_t      c;
	} uop_t;

	// special operand sources (bit 6 set), memory addresses otherwise
	localparam src_t SRC_ZERO = 7'h40;
	localparam src_t SRC_ONE  = 7'h41;
	localparam src_t SRC_DT   = 7'h42;
	localparam src_t SRC_QP   = 7'h43;
	localparam src_t SRC_QC   = 7'h44;
	localparam src_t SRC_QV   = 7'h45;
	localparam src_t SRC_R    = 7'h46;
	localparam src_t SRC_OX   = 7'h47;
	localparam src_t SRC_OY   = 7'h48;

	// scratch area of the state memory, plus the P00 and P11 covariance entries
	localparam addr_t A_S00 = 6'd20;
	localparam addr_t A_S11 = 6'd21;
	localparam addr_t A_T1  = 6'd22;
	localparam addr_t A_T2  = 6'd23;
	localparam addr_t A_DET = 6'd24;
	localparam addr_t A_N01 = 6'd25;
	localparam addr_t A_N10 = 6'd26;
	localparam addr_t A_E0D = 6'd31;
	localparam addr_t A_E1D = 6'd32;
	localparam addr_t A_P00 = 6'd4;
	localparam addr_t A_P11 = 6'd9;

	localparam int unsigned NUM_EST = 4;

	// program counter landmarks
	localparam logic [7:0] PC_INIT   = 8'd35;
	localparam logic [7:0] PC_UPDATE = 8'd56;

	localparam logic [63:0] ONE_Q48 = 64'h0001_0000_0000_0000;
	localparam logic [63:0] MAX64   = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] MIN64   = 64'h8000_0000_0000_0000;
	localparam logic [63:0] MAX48   = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] MIN48   = 64'hFFFF_8000_0000_0000;

	localparam logic [52:0] DT_RESET = 53'd281474976711;
	localparam logic [62:0] QP_RESET = 63'd703687;
	localparam logic [62:0] QC_RESET = 63'd1407374884;
	localparam logic [62:0] QV_RESET = 63'd2814749767107;
	localparam logic [62:0] R_RESET  = 63'd28147497671;

	localparam logic [2:0] CFG_DT = 3'd0;
	localparam logic [2:0] CFG_QP = 3'd1;
	localparam logic [2:0] CFG_QC = 3'd2;
	localparam logic [2:0] CFG_QV = 3'd3;
	localparam logic [2:0] CFG_R  = 3'd4;

	function automatic logic [63:0] mag(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	function automatic addr_t ea(input logic [1:0] i);
		return {4'b0, i};
	endfunction

	function automatic addr_t pa(input logic [1:0] i, input logic [1:0] j);
		return 6'd4 + {2'b0, i, j};
	endfunction

	function automatic addr_t ka(input logic [1:0] i, input logic j);
		return 6'd33 + {3'b0, i, j};
	endfunction

	function automatic addr_t ia(input logic r, input logic c);
		return 6'd27 + {4'b0, r, c};
	endfunction

	function automatic addr_t ta(input logic [1:0] i, input logic [1:0] j);
		return 6'd41 + {2'b0, i, j};
	endfunction

	function automatic src_t m(input addr_t a);
		return {1'b0, a};
	endfunction

	function automatic src_t qsrc(input logic [1:0] i, input logic [1:0] j);
		src_t s;
		s = SRC_ZERO;
		if (i == j) begin
			s = i[1] ? SRC_QV : SRC_QP;
		end else if ((i ^ j) == 2'b10) begin
			s = SRC_QC;
		end
		return s;
	endfunction

	function automatic uop_t mk(input uop_kind_t kind, input addr_t dst,
			input src_t a, input src_t b, input src_t c);
		uop_t u;
		u.kind = kind;
		u.dst  = dst;
		u.a    = a;
		u.b    = b;
		u.c    = c;
		return u;
	endfunction

	// microprogram: predict, branch, initialize or update
	function automatic uop_t decode(input logic [7:0] pc);
		uop_t       u;
		logic [7:0] k;
		logic [7:0] k2;
		u = mk(K_END, 6'd0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
		k = 8'd0;
		k2 = 8'd0;
		if (pc <= 8'd1) begin
			u = mk(K_MACCL, ea({1'b0, pc[0]}), m(ea({1'b0, pc[0]})), SRC_DT,
				m(ea({1'b1, pc[0]})));
		end else if (pc < 8'd10) begin
			k = pc - 8'd2;
			u = mk(K_MAC, pa({1'b0, k[2]}, k[1:0]), m(pa({1'b0, k[2]}, k[1:0])), SRC_DT,
				m(pa({1'b1, k[2]}, k[1:0])));
		end else if (pc < 8'd18) begin
			k = pc - 8'd10;
			u = mk(K_MAC, pa(k[2:1], {1'b0, k[0]}), m(pa(k[2:1], {1'b0, k[0]})), SRC_DT,
				m(pa(k[2:1], {1'b1, k[0]})));
		end else if (pc < 8'd34) begin
			k = pc - 8'd18;
			u = mk(K_MAC, pa(k[3:2], k[1:0]), m(pa(k[3:2], k[1:0])), qsrc(k[3:2], k[1:0]),
				SRC_ONE);
		end else if (pc == 8'd34) begin
			u = mk(K_BROBS, 6'd0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
		end else if (pc < 8'd55) begin
			k = pc - PC_INIT;
			if (k < 8'd4) begin
				u = mk(K_MAC, ea(k[1:0]),
					(k == 8'd0) ? SRC_OX : ((k == 8'd1) ? SRC_OY : SRC_ZERO),
					SRC_ZERO, SRC_ZERO);
			end else begin
				k2 = k - 8'd4;
				u = mk(K_MAC, pa(k2[3:2], k2[1:0]), qsrc(k2[3:2], k2[1:0]),
					SRC_ZERO, SRC_ZERO);
			end
		end else if (pc == 8'd55) begin
			u = mk(K_END, 6'd0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
		end else if (pc < 8'd70) begin
			case (pc)
				8'd56: u = mk(K_MAC, A_S00, m(pa(2'd0, 2'd0)), SRC_R, SRC_ONE);
				8'd57: u = mk(K_MAC, A_S11, m(pa(2'd1, 2'd1)), SRC_R, SRC_ONE);
				8'd58: u = mk(K_MAC, A_T1, SRC_ZERO, m(A_S00), m(A_S11));
				8'd59: u = mk(K_MAC, A_T2, SRC_ZERO, m(pa(2'd0, 2'd1)), m(pa(2'd1, 2'd0)));
				8'd60: u = mk(K_MACSUB, A_DET, m(A_T1), m(A_T2), SRC_ONE);
				8'd61: u = mk(K_BRDET, 6'd0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
				8'd62: u = mk(K_MACSUB, A_N01, SRC_ZERO, m(pa(2'd0, 2'd1)), SRC_ONE);
				8'd63: u = mk(K_MACSUB, A_N10, SRC_ZERO, m(pa(2'd1, 2'd0)), SRC_ONE);
				8'd64: u = mk(K_DIV, ia(1'b0, 1'b0), m(A_S11), m(A_DET), SRC_ZERO);
				8'd65: u = mk(K_DIV, ia(1'b0, 1'b1), m(A_N01), m(A_DET), SRC_ZERO);
				8'd66: u = mk(K_DIV, ia(1'b1, 1'b0), m(A_N10), m(A_DET), SRC_ZERO);
				8'd67: u = mk(K_DIV, ia(1'b1, 1'b1), m(A_S00), m(A_DET), SRC_ZERO);
				8'd68: u = mk(K_MACSUB, A_E0D, SRC_OX, m(ea(2'd0)), SRC_ONE);
				8'd69: u = mk(K_MACSUB, A_E1D, SRC_OY, m(ea(2'd1)), SRC_ONE);
				default: u = mk(K_END, 6'd0, SRC_ZERO, SRC_ZERO, SRC_ZERO);
			endcase
		end else if (pc < 8'd86) begin
			// gain: K = P[:,0:2] * inv(S)
			k = pc - 8'd70;
			if (!k[0]) begin
				u = mk(K_MAC, ka(k[3:2], k[1]), SRC_ZERO, m(pa(k[3:2], 2'd0)),
					m(ia(1'b0, k[1])));
			end else begin
				u = mk(K_MAC, ka(k[3:2], k[1]), m(ka(k[3:2], k[1])), m(pa(k[3:2], 2'd1)),
					m(ia(1'b1, k[1])));
			end
		end else if (pc < 8'd94) begin
			k = pc - 8'd86;
			if (!k[0]) begin
				u = mk(K_MAC, ta(k[2:1], 2'd0), SRC_ZERO, m(ka(k[2:1], 1'b0)), m(A_E0D));
			end else begin
				u = mk(K_MAC, ta(k[2:1], 2'd0), m(ta(k[2:1], 2'd0)), m(ka(k[2:1], 1'b1)),
					m(A_E1D));
			end
		end else if (pc < 8'd98) begin
			k = pc - 8'd94;
			u = mk(K_MACCL, ea(k[1:0]), m(ea(k[1:0])), m(ta(k[1:0], 2'd0)), SRC_ONE);
		end else if (pc < 8'd130) begin
			// K*H*P terms into scratch, all four rows
			k = pc - 8'd98;
			if (!k[0]) begin
				u = mk(K_MAC, ta(k[4:3], k[2:1]), SRC_ZERO, m(ka(k[4:3], 1'b0)),
					m(pa(2'd0, k[2:1])));
			end else begin
				u = mk(K_MAC, ta(k[4:3], k[2:1]), m(ta(k[4:3], k[2:1])),
					m(ka(k[4:3], 1'b1)), m(pa(2'd1, k[2:1])));
			end
		end else if (pc < 8'd146) begin
			k = pc - 8'd130;
			u = mk(K_MACSUB, pa(k[3:2], k[1:0]), m(pa(k[3:2], k[1:0])),
				m(ta(k[3:2], k[1:0])), SRC_ONE);
		end
		return u;
	endfunction

endpackage

### sv/cvkt_div.sv
// ============================================================================
// cvkt_div - iterative fixed-point divider
// Computes round(num * 2^48 / den) to nearest, ties away from zero, one
// quotient bit per cycle, saturated to the signed 64-bit range.
// ============================================================================
module cvkt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [63:0] quo
);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_t;

	dstate_t      st_q;
	logic [6:0]   cnt_q;
	logic [127:0] dv_q;
	logic [63:0]  ud_q;
	logic [63:0]  r_q;
	logic [63:0]  q_q;
	logic         ovf_q;
	logic         neg_q;
	logic         done_q;
	logic [63:0]  quo_q;

	logic [63:0] r_sh;
	logic        ge;
	logic        rnd;
	logic [63:0] q_fin;
	logic        ovf_fin;

	always_comb begin
		r_sh    = {r_q[62:0], dv_q[127]};
		ge      = r_q[63] || (r_sh >= ud_q);
		rnd     = (r_q >= (ud_q - r_q));
		q_fin   = rnd ? (q_q + 64'd1) : q_q;
		ovf_fin = ovf_q || (rnd && (&q_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				D_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						st_q  <= D_RUN;
					end
				end
				D_RUN: begin
					cnt_q <= cnt_q + 7'd1;
					if (&cnt_q) begin
						st_q <= D_FIN;
					end
				end
				D_FIN: begin
					done_q <= 1'b1;
					st_q   <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				if (start) begin
					dv_q  <= {16'b0, cvkt_pkg::mag(num), 48'b0};
					ud_q  <= cvkt_pkg::mag(den);
					neg_q <= num[63] ^ den[63];
					r_q   <= '0;
					q_q   <= '0;
					ovf_q <= 1'b0;
				end
			end
			D_RUN: begin
				dv_q  <= {dv_q[126:0], 1'b0};
				r_q   <= ge ? (r_sh - ud_q) : r_sh;
				q_q   <= {q_q[62:0], ge};
				ovf_q <= ovf_q | q_q[63];
			end
			D_FIN: begin
				if (ovf_fin || q_fin[63]) begin
					quo_q <= neg_q ? cvkt_pkg::MIN64 : cvkt_pkg::MAX64;
				end else begin
					quo_q <= neg_q ? (64'd0 - q_fin) : q_fin;
				end
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

### sv/constant_velocity_kalman_tracker.sv
// ============================================================================
// constant_velocity_kalman_tracker - 2-D constant-velocity Kalman tracker
// Predicts [x, y, vx, vy] each tick and folds in an optional position
// observation, in Q16.32 state and Q16.48 covariance fixed point.
// ============================================================================
// Usage:
// - Slave stream: one item per servo tick. tdata holds obs_x, obs_y and
//   tick_time; tuser holds obs_valid. s_tready is high only while the
//   sequencer is idle, so the block works on one tick at a time.
// - Master stream: one item per tick with the estimate after that tick.
//   The result sits in an output register; the next tick may be taken
//   while it waits, and the sequencer holds at its end until the register
//   frees up when the receiver stalls.
// - Config channel: cfg_index selects step_dt, q_position, q_cross,
//   q_velocity or r_observation (0 to 4); higher indexes are dropped.
//   cfg_ready is always high. Write only while no tick is in flight.
// - Datapath: each micro-op reads up to three operands from the state memory
//   through one read port and runs a 64x64 product as four 32x32 partial
//   products; each 2x2 inverse element goes through the bit-serial divider.
// - Reset clears the estimate, covariance, tracking flag and update time
//   (through per-entry valid bits) and loads the register defaults.
// ============================================================================
module constant_velocity_kalman_tracker (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // obs_x[47:0], obs_y[95:48], tick_time[127:96]
	input  logic [0:0]   s_tuser,   // obs_valid[0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [351:0] m_tdata,   // est_x, est_y, est_vx, est_vy (48 each),
	                                // var_x, var_y (63 each), update_time (32), 2'b0
	output logic [0:0]   m_tuser,   // tracking[0]
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE, S_FETCH, S_RDB, S_RDC, S_CAP, S_MUL, S_RND, S_DIV, S_WR, S_DONE
	} state_t;

	// configuration registers
	logic [52:0] dt_q;
	logic [62:0] qp_q;
	logic [62:0] qc_q;
	logic [62:0] qv_q;
	logic [62:0] r_q;

	// sequencer
	state_t           state_q;
	logic [7:0]       pc_q;
	cvkt_pkg::uop_t   u;
	logic             zero_q;
	logic [63:0]      vld_q;
	logic             tracking_q;
	logic [31:0]      utime_q;

	// captured tick
	logic             obsv_q;
	logic [47:0]      ox_q;
	logic [47:0]      oy_q;
	logic [31:0]      tick_q;

	// state memory: estimate, covariance and scratch
	logic [63:0]      mem [64];
	cvkt_pkg::addr_t  rd_addr;
	logic [63:0]      rd_q;
	logic             rdv_q;
	cvkt_pkg::src_t   rsel_q;
	cvkt_pkg::src_t   rsel_d;
	logic             mem_we;
	logic [63:0]      cur_opnd;

	// multiply-accumulate datapath
	logic [63:0]      opa_q;
	logic [63:0]      opb_q;
	logic [63:0]      ma_q;
	logic [63:0]      mb_q;
	logic             neg_q;
	logic [127:0]     acc_q;
	logic [1:0]       mc_q;
	logic [63:0]      mulres_q;
	logic [63:0]      pp;
	logic [6:0]       sh;
	logic [127:0]     rounded;
	logic [63:0]      mag_rnd;
	logic [65:0]      sum;
	logic [63:0]      sat64;
	logic [63:0]      res;

	// divider
	logic             div_start;
	logic             div_done;
	logic [63:0]      div_quo;

	// shadows of the state shown at the output
	logic [47:0]      est_q [cvkt_pkg::NUM_EST];
	logic [63:0]      p00_q;
	logic [63:0]      p11_q;

	logic             m_tvalid_q;
	logic [351:0]     m_tdata_q;
	logic             m_tuser_q;

	logic [62:0]      var_x;
	logic [62:0]      var_y;

	assign u         = cvkt_pkg::decode(pc_q);
	assign s_tready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;
	assign div_start = (state_q == S_CAP) && (u.kind == cvkt_pkg::K_DIV);
	assign mem_we    = (state_q == S_WR);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dt_q <= cvkt_pkg::DT_RESET;
			qp_q <= cvkt_pkg::QP_RESET;
			qc_q <= cvkt_pkg::QC_RESET;
			qv_q <= cvkt_pkg::QV_RESET;
			r_q  <= cvkt_pkg::R_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				cvkt_pkg::CFG_DT: dt_q <= cfg_data[52:0];
				cvkt_pkg::CFG_QP: qp_q <= cfg_data[62:0];
				cvkt_pkg::CFG_QC: qc_q <= cfg_data[62:0];
				cvkt_pkg::CFG_QV: qv_q <= cfg_data[62:0];
				cvkt_pkg::CFG_R:  r_q  <= cfg_data[62:0];
				default: ;
			endcase
		end
	end

	// read address for the operand that the current state fetches
	always_comb begin
		case (state_q)
			S_FETCH: rsel_d = u.a;
			S_RDB:   rsel_d = u.b;
			S_RDC:   rsel_d = u.c;
			default: rsel_d = cvkt_pkg::SRC_ZERO;
		endcase
		rd_addr = rsel_d[5:0];
	end

	// operand of the read issued last cycle; unwritten state entries read as zero
	always_comb begin
		if (!rsel_q[6]) begin
			cur_opnd = rdv_q ? rd_q : 64'd0;
		end else begin
			case (rsel_q)
				cvkt_pkg::SRC_ONE: cur_opnd = cvkt_pkg::ONE_Q48;
				cvkt_pkg::SRC_DT:  cur_opnd = {11'b0, dt_q};
				cvkt_pkg::SRC_QP:  cur_opnd = {1'b0, qp_q};
				cvkt_pkg::SRC_QC:  cur_opnd = {1'b0, qc_q};
				cvkt_pkg::SRC_QV:  cur_opnd = {1'b0, qv_q};
				cvkt_pkg::SRC_R:   cur_opnd = {1'b0, r_q};
				cvkt_pkg::SRC_OX:  cur_opnd = {{16{ox_q[47]}}, ox_q};
				cvkt_pkg::SRC_OY:  cur_opnd = {{16{oy_q[47]}}, oy_q};
				default:           cur_opnd = 64'd0;
			endcase
		end
	end

	// partial product, rounding, accumulate and saturate
	always_comb begin
		pp      = ma_q[{mc_q[1], 5'b0} +: 32] * mb_q[{mc_q[0], 5'b0} +: 32];
		sh      = {({1'b0, mc_q[1]} + {1'b0, mc_q[0]}), 5'b0};
		rounded = acc_q + 128'h8000_0000_0000;
		mag_rnd = {1'b0, rounded[110:48]};
		if (u.kind == cvkt_pkg::K_MACSUB) begin
			sum = {{2{opa_q[63]}}, opa_q} - {{2{mulres_q[63]}}, mulres_q};
		end else begin
			sum = {{2{opa_q[63]}}, opa_q} + {{2{mulres_q[63]}}, mulres_q};
		end
		if (sum[65:63] == 3'b000 || sum[65:63] == 3'b111) begin
			sat64 = sum[63:0];
		end else begin
			sat64 = sum[65] ? cvkt_pkg::MIN64 : cvkt_pkg::MAX64;
		end
		res = sat64;
		if (u.kind == cvkt_pkg::K_DIV) begin
			res = div_quo;
		end else if (u.kind == cvkt_pkg::K_MACCL) begin
			if (!(sat64[63:47] == 17'h0 || sat64[63:47] == 17'h1FFFF)) begin
				res = sat64[63] ? cvkt_pkg::MIN48 : cvkt_pkg::MAX48;
			end
		end
	end

	assign var_x = p00_q[63] ? 63'd0 : p00_q[62:0];
	assign var_y = p11_q[63] ? 63'd0 : p11_q[62:0];

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			pc_q       <= '0;
			mc_q       <= '0;
			zero_q     <= 1'b0;
			vld_q      <= '0;
			tracking_q <= 1'b0;
			utime_q    <= '0;
			for (int i = 0; i < cvkt_pkg::NUM_EST; i++) begin
				est_q[i] <= '0;
			end
			p00_q      <= '0;
			p11_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tuser_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						pc_q    <= '0;
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					case (u.kind)
						cvkt_pkg::K_BROBS: begin
							if (!obsv_q) begin
								state_q <= S_DONE;
							end else begin
								pc_q <= tracking_q ? cvkt_pkg::PC_UPDATE : cvkt_pkg::PC_INIT;
							end
						end
						cvkt_pkg::K_BRDET: begin
							// singular innovation matrix: keep the prediction
							if (zero_q) begin
								state_q <= S_DONE;
							end else begin
								pc_q <= pc_q + 8'd1;
							end
						end
						cvkt_pkg::K_END: begin
							tracking_q <= 1'b1;
							utime_q    <= tick_q;
							state_q    <= S_DONE;
						end
						default: state_q <= S_RDB;
					endcase
				end
				S_RDB: state_q <= S_RDC;
				S_RDC: state_q <= S_CAP;
				S_CAP: begin
					mc_q    <= '0;
					state_q <= (u.kind == cvkt_pkg::K_DIV) ? S_DIV : S_MUL;
				end
				S_MUL: begin
					mc_q <= mc_q + 2'd1;
					if (&mc_q) begin
						state_q <= S_RND;
					end
				end
				S_RND: state_q <= S_WR;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_WR;
					end
				end
				S_WR: begin
					vld_q[u.dst] <= 1'b1;
					zero_q       <= (res == 64'd0);
					if (u.dst < 6'(cvkt_pkg::NUM_EST)) begin
						est_q[u.dst[1:0]] <= res[47:0];
					end
					if (u.dst == cvkt_pkg::A_P00) begin
						p00_q <= res;
					end
					if (u.dst == cvkt_pkg::A_P11) begin
						p11_q <= res;
					end
					pc_q    <= pc_q + 8'd1;
					state_q <= S_FETCH;
				end
				S_DONE: begin
					// hold here until the output register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tuser_q  <= tracking_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers: captured tick, operands and product
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_tvalid) begin
			obsv_q <= s_tuser[0];
			ox_q   <= s_tdata[47:0];
			oy_q   <= s_tdata[95:48];
			tick_q <= s_tdata[127:96];
		end
		rsel_q <= rsel_d;
		case (state_q)
			S_RDB: opa_q <= cur_opnd;
			S_RDC: opb_q <= cur_opnd;
			S_CAP: begin
				ma_q  <= cvkt_pkg::mag(opb_q);
				mb_q  <= cvkt_pkg::mag(cur_opnd);
				neg_q <= opb_q[63] ^ cur_opnd[63];
				acc_q <= '0;
			end
			S_MUL: acc_q <= acc_q + ({64'b0, pp} << sh);
			S_RND: begin
				if (|rounded[127:111]) begin
					mulres_q <= neg_q ? cvkt_pkg::MIN64 : cvkt_pkg::MAX64;
				end else begin
					mulres_q <= neg_q ? (64'd0 - mag_rnd) : mag_rnd;
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					m_tdata_q <= {2'b0, utime_q, var_y, var_x,
						est_q[3], est_q[2], est_q[1], est_q[0]};
				end
			end
			default: ;
		endcase
	end

	// state memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[u.dst] <= res;
		end
		rd_q  <= mem[rd_addr];
		rdv_q <= vld_q[rd_addr];
	end

	cvkt_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (opa_q),
		.den    (opb_q),
		.done   (div_done),
		.quo    (div_quo)
	);

endmodule

### sv/cvkt_checker.sv
// ============================================================================
// cvkt_checker - port-level checks for the tracker
// Watches the stream ports for tracking and sequencing rules.
// ============================================================================
module cvkt_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [351:0] m_tdata,
	input logic [0:0]   m_tuser
);

	logic seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (m_tvalid && m_tready && m_tuser[0]) begin
			seen_q <= 1'b1;
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one tick at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while busy");

	// tracking never drops once shown
	a_track_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && seen_q |-> m_tuser[0])
		else $error("tracking dropped");

	// no update time before tracking starts
	a_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata[349:318] == 32'd0)
		else $error("update time set before tracking");

endmodule

bind constant_velocity_kalman_tracker cvkt_checker u_chk (.*);

### verif/constant_velocity_kalman_tracker_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// constant_velocity_kalman_tracker_checker - tracker estimate scoreboard
// Watches the config, tick and estimate channels, keeps its own fixed-point
// copy of the filter and compares every estimate item field by field.
// ============================================================================
module constant_velocity_kalman_tracker_checker import cvkt_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	input  logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic [0:0]   s_tuser,
	input  logic         m_tvalid,
	input  logic         m_tready,
	input  logic [351:0] m_tdata,
	input  logic [0:0]   m_tuser,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [63:0]  cfg_data,
	output int           err_count,
	output int           pending
);

	typedef struct packed {
		logic [47:0] ex, ey, evx, evy;
		logic [62:0] vx, vy;
		logic [31:0] upd;
		logic        trk;
	} estimate_t;

	estimate_t          est_q[$];
	logic [52:0]        dt_reg;
	logic [62:0]        qp_reg, qc_reg, qv_reg, r_reg;
	logic signed [63:0] state_v[4];
	logic signed [63:0] cov[16];
	logic               tracking;
	logic [31:0]        last_upd;

	function automatic logic [63:0] add_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) return s[64] ? MIN64 : MAX64;
		return s[63:0];
	endfunction

	function automatic logic [63:0] sub_sat(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} - {b[63], b};
		if (s[64] != s[63]) return s[64] ? MIN64 : MAX64;
		return s[63:0];
	endfunction

	function automatic logic [63:0] abs64(input logic [63:0] v);
		return v[63] ? (64'd0 - v) : v;
	endfunction

	// round(a*b / 2^48), ties away from zero, saturated
	function automatic logic [63:0] mul_q48(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		logic         neg;
		neg = a[63] ^ b[63];
		p = {64'd0, abs64(a)} * {64'd0, abs64(b)} + (128'd1 << 47);
		p = p >> 48;
		if (p > {64'd0, MAX64}) return neg ? MIN64 : MAX64;
		return neg ? (64'd0 - p[63:0]) : p[63:0];
	endfunction

	// round(num * 2^48 / den), den nonzero
	function automatic logic [63:0] div_q48(input logic [63:0] num, input logic [63:0] den);
		logic [127:0] n, d, q, r;
		logic         neg;
		neg = num[63] ^ den[63];
		n = {64'd0, abs64(num)} << 48;
		d = {64'd0, abs64(den)};
		q = n / d;
		r = n % d;
		if (r >= d - r) q = q + 1;
		if (q > {64'd0, MAX64}) return neg ? MIN64 : MAX64;
		return neg ? (64'd0 - q[63:0]) : q[63:0];
	endfunction

	function automatic logic [63:0] clamp48(input logic [63:0] v);
		if (!v[63] && v[63:47] != 17'd0) return MAX48;
		if (v[63] && v[63:47] != 17'h1FFFF) return MIN48;
		return v;
	endfunction

	function automatic logic [63:0] qterm(input int i, input int j);
		if (i == j) return (i < 2) ? {1'b0, qp_reg} : {1'b0, qv_reg};
		if ((i ^ j) == 2) return {1'b0, qc_reg};
		return 64'd0;
	endfunction

	// advance the filter by one tick and queue the estimate it yields
	task automatic track_tick(input logic valid, input logic [47:0] zx,
			input logic [47:0] zy, input logic [31:0] t);
		logic [63:0] dt, ox, oy, xp[4], mm[4][4], pp[4][4];
		logic [63:0] s00, s01, s10, s11, det, e0, e1, inv[2][2], kg[4][2], v;
		estimate_t   e;
		dt = {11'd0, dt_reg};
		ox = {{16{zx[47]}}, zx};
		oy = {{16{zy[47]}}, zy};
		xp[0] = clamp48(add_sat(state_v[0], mul_q48(dt, state_v[2])));
		xp[1] = clamp48(add_sat(state_v[1], mul_q48(dt, state_v[3])));
		xp[2] = state_v[2];
		xp[3] = state_v[3];
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				mm[i][j] = (i < 2) ? add_sat(cov[i*4+j], mul_q48(dt, cov[(i+2)*4+j]))
					: cov[i*4+j];
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++) begin
				v = (j < 2) ? add_sat(mm[i][j], mul_q48(dt, mm[i][j+2])) : mm[i][j];
				pp[i][j] = add_sat(v, qterm(i, j));
			end
		for (int i = 0; i < 4; i++) begin
			state_v[i] = xp[i];
			for (int j = 0; j < 4; j++) cov[i*4+j] = pp[i][j];
		end
		if (valid && !tracking) begin
			// first observation: load position, zero velocity, P = Q
			state_v[0] = ox;
			state_v[1] = oy;
			state_v[2] = 64'd0;
			state_v[3] = 64'd0;
			for (int i = 0; i < 4; i++)
				for (int j = 0; j < 4; j++) cov[i*4+j] = qterm(i, j);
			last_upd = t;
			tracking = 1'b1;
		end else if (valid) begin
			s00 = add_sat(pp[0][0], {1'b0, r_reg});
			s01 = pp[0][1];
			s10 = pp[1][0];
			s11 = add_sat(pp[1][1], {1'b0, r_reg});
			det = sub_sat(mul_q48(s00, s11), mul_q48(s01, s10));
			// singular innovation: keep the prediction
			if (det != 64'd0) begin
				e0 = ox - xp[0];
				e1 = oy - xp[1];
				inv[0][0] = div_q48(s11, det);
				inv[0][1] = div_q48(sub_sat(64'd0, s01), det);
				inv[1][0] = div_q48(sub_sat(64'd0, s10), det);
				inv[1][1] = div_q48(s00, det);
				for (int i = 0; i < 4; i++)
					for (int j = 0; j < 2; j++)
						kg[i][j] = add_sat(mul_q48(pp[i][0], inv[0][j]),
							mul_q48(pp[i][1], inv[1][j]));
				for (int i = 0; i < 4; i++) begin
					state_v[i] = clamp48(add_sat(xp[i],
						add_sat(mul_q48(kg[i][0], e0), mul_q48(kg[i][1], e1))));
					for (int j = 0; j < 4; j++)
						cov[i*4+j] = sub_sat(pp[i][j],
							add_sat(mul_q48(kg[i][0], pp[0][j]), mul_q48(kg[i][1], pp[1][j])));
				end
				last_upd = t;
			end
		end
		e.ex  = state_v[0][47:0];
		e.ey  = state_v[1][47:0];
		e.evx = state_v[2][47:0];
		e.evy = state_v[3][47:0];
		e.vx  = cov[0][63] ? 63'd0 : cov[0][62:0];
		e.vy  = cov[5][63] ? 63'd0 : cov[5][62:0];
		e.upd = last_upd;
		e.trk = tracking;
		est_q.push_back(e);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			err_count++;
			if (err_count <= 10)
				$display("%0t: %s mismatch, expected %h, got %h", $realtime, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			est_q.delete();
			dt_reg   <= DT_RESET;
			qp_reg   <= QP_RESET;
			qc_reg   <= QC_RESET;
			qv_reg   <= QV_RESET;
			r_reg    <= R_RESET;
			tracking <= 1'b0;
			last_upd <= 32'd0;
			for (int i = 0; i < 4; i++) state_v[i] <= 64'd0;
			for (int i = 0; i < 16; i++) cov[i] <= 64'd0;
			err_count <= 0;
			pending   <= 0;
		end else begin
			// compare first: an item taken at this edge cannot be answered at it
			if (m_tvalid && m_tready) begin
				if (est_q.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("%0t: estimate item with none expected", $realtime);
				end else begin
					estimate_t w;
					w = est_q.pop_front();
					check_field("est_x", w.ex, m_tdata[47:0]);
					check_field("est_y", w.ey, m_tdata[95:48]);
					check_field("est_vx", w.evx, m_tdata[143:96]);
					check_field("est_vy", w.evy, m_tdata[191:144]);
					check_field("var_x", w.vx, m_tdata[254:192]);
					check_field("var_y", w.vy, m_tdata[317:255]);
					check_field("update_time", w.upd, m_tdata[349:318]);
					check_field("pad", 64'd0, m_tdata[351:350]);
					check_field("tracking", w.trk, m_tuser[0]);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_DT: dt_reg = cfg_data[52:0];
					CFG_QP: qp_reg = cfg_data[62:0];
					CFG_QC: qc_reg = cfg_data[62:0];
					CFG_QV: qv_reg = cfg_data[62:0];
					CFG_R:  r_reg  = cfg_data[62:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				track_tick(s_tuser[0], s_tdata[47:0], s_tdata[95:48], s_tdata[127:96]);
			pending = est_q.size();
		end
	end

endmodule

### verif/constant_velocity_kalman_tracker_test.sv
`timescale 1ns / 1ps
// ============================================================================
// constant_velocity_kalman_tracker_test - tracker testbench top
// Drives ticks along noisy straight tracks plus noise items through several
// register settings and stall patterns; the checker predicts and compares.
// ============================================================================
module constant_velocity_kalman_tracker_test;
	import cvkt_pkg::*;

	localparam int STALL_LIMIT = 40000;  // cycles without any item moving
	localparam int SETTLE      = 2500;   // longer than a full update pass
	localparam int PHASE_TICKS = 65;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [127:0] s_tdata;   // obs_x[47:0], obs_y[95:48], tick_time[127:96]
	logic [0:0]   s_tuser;   // obs_valid[0]
	logic         m_tvalid;
	logic         m_tready;
	logic [351:0] m_tdata;   // est_x, est_y, est_vx, est_vy, var_x, var_y, update_time
	logic [0:0]   m_tuser;   // tracking[0]
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [63:0]  cfg_data;
	int           err_count;
	int           pending;

	int     send_idle;     // percent of cycles the sender holds back
	int     recv_idle;     // percent of cycles the receiver stalls
	bit     hold_req;      // ask the receiver for one long stall
	bit     hold_done;
	int     tick_count;
	longint tx, ty, tvx, tvy;
	logic [31:0] tstamp;

	constant_velocity_kalman_tracker u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	constant_velocity_kalman_tracker_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .err_count(err_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off so the block backs up
	initial begin
		m_tready  = 1'b0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_done) begin
				m_tready = 1'b0;
				repeat (8000) @(negedge clk);
				hold_done = 1'b1;
			end
			m_tready = ($urandom_range(0, 99) >= recv_idle);
		end
	end

	// watchdog: end the run when nothing moves for too long
	initial begin
		int quiet;
		quiet = 0;
		forever begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= STALL_LIMIT) begin
				$display("constant_velocity_kalman_tracker_test: done, errors");
				$finish;
			end
		end
	end

	// offer one tick item and hold it until taken
	task automatic send_tick(input logic valid, input logic [47:0] x, input logic [47:0] y,
			input logic [31:0] t);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata  = {t, y, x};
		s_tuser  = valid;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		tick_count++;
		// switch the stall pattern as the run advances
		if (tick_count == 140) begin
			send_idle = 84;
			recv_idle = 25;
		end else if (tick_count == 280) begin
			send_idle = 0;
			recv_idle = 0;
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(negedge clk);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drain: every estimate back, then let the sequencer go quiet
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_all(input logic [63:0] dt, input logic [63:0] qp,
			input logic [63:0] qc, input logic [63:0] qv, input logic [63:0] r);
		write_reg(CFG_DT, dt);
		write_reg(CFG_QP, qp);
		write_reg(CFG_QC, qc);
		write_reg(CFG_QV, qv);
		write_reg(CFG_R, r);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// one random tick: mostly observations along the track, some noise
	task automatic random_tick();
		int pick;
		logic [47:0] nx, ny;
		pick = $urandom_range(0, 99);
		tx += tvx;
		ty += tvy;
		tstamp = tstamp + $urandom_range(1, 3);
		if (pick < 65) begin
			nx = tx + $urandom_range(0, 1 << 24) - (1 << 23);
			ny = ty + $urandom_range(0, 1 << 24) - (1 << 23);
			send_tick(1'b1, nx, ny, tstamp);
		end else if (pick < 85) begin
			// coasting tick; observation fields carry junk
			send_tick(1'b0, rand64(), rand64(), $urandom);
		end else begin
			// wild observation anywhere in range
			send_tick(1'b1, rand64(), rand64(), $urandom);
		end
	endtask

	task automatic run_phase();
		tx  = $signed($urandom_range(0, 1 << 30)) - (1 << 29);
		ty  = $signed($urandom_range(0, 1 << 30)) - (1 << 29);
		tx  = tx <<< 10;
		ty  = ty <<< 10;
		tvx = $signed($urandom_range(0, 1 << 28)) - (1 << 27);
		tvy = $signed($urandom_range(0, 1 << 28)) - (1 << 27);
		repeat (PHASE_TICKS) random_tick();
		settle();
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = CFG_DT;
		cfg_data   = '0;
		send_idle  = 25;
		recv_idle  = 84;
		hold_req   = 1'b0;
		tick_count = 0;
		tstamp     = 32'd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: coast before tracking, then extreme observations
		send_tick(1'b0, 48'd0, 48'd0, 32'd1);
		send_tick(1'b0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
		send_tick(1'b0, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 32'd2);
		send_tick(1'b1, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000, 32'd10);   // initialize
		send_tick(1'b1, 48'h8000_0000_0000, 48'h7FFF_FFFF_FFFF, 32'd11);
		send_tick(1'b1, 48'd0, 48'd0, 32'hFFFF_FFFF);
		send_tick(1'b0, 48'hAAAA_AAAA_AAAA, 48'h5555_5555_5555, 32'd0);
		send_tick(1'b1, 48'h0001_0000_0000, 48'hFFFF_0000_0000, 32'd13);
		send_tick(1'b1, 48'h0001_0000_0000, 48'hFFFF_0000_0000, 32'd14);
		send_tick(1'b0, 48'd0, 48'd0, 32'd15);
		send_tick(1'b1, 48'h7FFF_FFFF_FFFF, 48'h7FFF_FFFF_FFFF, 32'd16);
		send_tick(1'b1, 48'h8000_0000_0000, 48'h8000_0000_0000, 32'd17);
		settle();

		// reset values written back, out-of-range indexes dropped
		write_all({11'd0, DT_RESET}, {1'b0, QP_RESET}, {1'b0, QC_RESET},
			{1'b0, QV_RESET}, {1'b0, R_RESET});
		write_reg(3'd5, rand64());
		write_reg(3'd6, rand64());
		write_reg(3'd7, rand64());
		run_phase();

		// zero step, the prediction stands still; receiver holds off meanwhile
		write_all(64'd0, rand64() >> 24, rand64() >> 24, rand64() >> 20, rand64() >> 20);
		hold_req = 1'b1;
		run_phase();

		// large step and largest noise: saturation everywhere
		write_all(64'h0010_0000_0000_0000, {1'b0, {63{1'b1}}}, {1'b0, {63{1'b1}}},
			{1'b0, {63{1'b1}}}, {1'b0, {63{1'b1}}});
		run_phase();

		// no noise at all: the covariance collapses and S turns singular
		write_all(64'd0, 64'd0, 64'd0, 64'd0, 64'd0);
		run_phase();

		// full-width random values, upper bits masked by the block
		write_all(rand64(), rand64(), rand64(), rand64(), rand64());
		run_phase();

		write_all({11'd0, DT_RESET}, {1'b0, QP_RESET}, {1'b0, QC_RESET},
			{1'b0, QV_RESET}, {1'b0, R_RESET});
		run_phase();

		if (err_count == 0 && pending == 0)
			$display("constant_velocity_kalman_tracker_test: done, clean");
		else
			$display("constant_velocity_kalman_tracker_test: done, errors");
		$finish;
	end

endmodule
